// File: hw/rtl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

    // request kinds as they arrive on req_type
    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_kind_t;

    // field widths fixed by the interface
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 8;
    localparam int unsigned COUNT_W = 9;

    // entries in the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // classified command; key holds the prefix of a write or the address of a lookup
    typedef struct packed {
        cmd_kind_t           kind;
        logic [IDX_W-1:0]    index;
        logic [ADDR_W-1:0]   key;
        logic [ADDR_W-1:0]   mask;
        logic [PORT_W-1:0]   port;
    } lpm_cmd_t;

    // one routing table entry
    typedef struct packed {
        logic [ADDR_W-1:0]   prefix;
        logic [ADDR_W-1:0]   mask;
        logic [PORT_W-1:0]   port;
    } lpm_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/lpm_front.sv
`default_nettype none

module lpm_front #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [lpm_pkg::IDX_W-1:0]     entry_index,
    input  wire logic [lpm_pkg::ADDR_W-1:0]    entry_prefix,
    input  wire logic [lpm_pkg::ADDR_W-1:0]    entry_mask,
    input  wire logic [lpm_pkg::PORT_W-1:0]    entry_port,
    input  wire logic [lpm_pkg::ADDR_W-1:0]    dest_ip,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output lpm_pkg::lpm_cmd_t                  push_cmd
);
    import lpm_pkg::*;

    logic      cmd_valid_reg;
    logic      cmd_valid_next;
    lpm_cmd_t  cmd_reg;
    lpm_cmd_t  cmd_next;
    logic      in_accept;
    logic      idx_in_range;
    cmd_kind_t kind;

    assign in_stall  = cmd_valid_reg && !push_ready;
    assign in_accept = in_valid && !in_stall;

    assign kind         = cmd_kind_t'(req_type);
    assign idx_in_range = 32'(entry_index) < 32'(TABLE_DEPTH);

    always_comb
    begin
        cmd_next.kind  = kind;
        cmd_next.index = entry_index;
        cmd_next.key   = (kind == CMD_LOOKUP) ? dest_ip : entry_prefix;
        cmd_next.mask  = entry_mask;
        cmd_next.port  = entry_port;
    end

    // writes beyond the table are dropped here
    always_comb
    begin
        cmd_valid_next = cmd_valid_reg && !push_ready;
        if (in_accept)
        begin
            cmd_valid_next = (kind == CMD_LOOKUP) || idx_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign push_valid = cmd_valid_reg;
    assign push_cmd   = cmd_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lpm_queue.sv
`default_nettype none

module lpm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire lpm_pkg::lpm_cmd_t push_cmd,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output lpm_pkg::lpm_cmd_t      pop_cmd
);
    import lpm_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    lpm_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// File: hw/rtl/lpm_back.sv
`default_nettype none

module lpm_back #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lpm_pkg::COUNT_W-1:0]   entries_in_use,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire lpm_pkg::lpm_cmd_t             cmd,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic [lpm_pkg::IDX_W-1:0]          route_index,
    output logic [lpm_pkg::PORT_W-1:0]         out_port
);
    import lpm_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    lpm_entry_t          mem [TABLE_DEPTH];
    lpm_entry_t          rd_data_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                rd_valid_reg;

    state_t              state_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [CW-1:0]       limit_reg;
    logic [CW-1:0]       limit_sat;
    logic [ADDR_W-1:0]   dest_reg;

    logic                best_hit_reg;
    logic [ADDR_W-1:0]   best_mask_reg;
    logic [AW-1:0]       best_idx_reg;
    logic [PORT_W-1:0]   best_port_reg;

    logic                out_valid_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    route_index_reg;
    logic [PORT_W-1:0]   out_port_reg;

    logic                take;
    logic                is_write;
    logic                match;
    logic                out_free;
    logic [AW+IDX_W-1:0] wr_idx_wide;
    logic [AW-1:0]       wr_addr;
    logic [AW+IDX_W-1:0] best_idx_wide;

    assign cmd_ready = state_reg == ST_IDLE;
    assign take      = cmd_valid && cmd_ready;
    assign is_write  = cmd.kind == CMD_WRITE;

    assign wr_idx_wide   = {{AW{1'b0}}, cmd.index};
    assign wr_addr       = wr_idx_wide[AW-1:0];
    assign best_idx_wide = {{IDX_W{1'b0}}, best_idx_reg};

    assign limit_sat = (32'(entries_in_use) >= 32'(TABLE_DEPTH)) ?
                       CW'(TABLE_DEPTH) : CW'(entries_in_use);

    assign cnt_next = cnt_reg + 1'b1;
    assign match    = ((dest_reg & rd_data_reg.mask) == rd_data_reg.prefix) &&
                      (rd_data_reg.mask >= best_mask_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (take && is_write)
        begin
            mem[wr_addr] <= '{prefix: cmd.key, mask: cmd.mask, port: cmd.port};
        end
        rd_data_reg <= mem[cnt_reg[AW-1:0]];
        rd_idx_reg  <= cnt_reg[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            limit_reg       <= '0;
            dest_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            best_hit_reg    <= 1'b0;
            best_mask_reg   <= '0;
            best_idx_reg    <= '0;
            best_port_reg   <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            route_index_reg <= '0;
            out_port_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= state_reg == ST_SCAN;

            // a finishing lookup reloads the result register itself
            if (out_valid_reg && !out_stall && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            // compare stage on the entry read last cycle
            if (rd_valid_reg && match)
            begin
                best_hit_reg  <= 1'b1;
                best_mask_reg <= rd_data_reg.mask;
                best_idx_reg  <= rd_idx_reg;
                best_port_reg <= rd_data_reg.port;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take && !is_write)
                    begin
                        dest_reg      <= cmd.key;
                        limit_reg     <= limit_sat;
                        cnt_reg       <= '0;
                        best_hit_reg  <= 1'b0;
                        best_mask_reg <= '0;
                        best_idx_reg  <= '0;
                        best_port_reg <= '0;
                        state_reg     <= (limit_sat == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_next;
                    if (cnt_next == limit_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        found_reg       <= best_hit_reg;
                        route_index_reg <= best_hit_reg ? best_idx_wide[IDX_W-1:0] : '0;
                        out_port_reg    <= best_hit_reg ? best_port_reg : '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign route_index = route_index_reg;
    assign out_port    = out_port_reg;

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("table read outside a scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> cnt_reg <= limit_reg)
        else $error("scan ran past the entry count");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> route_index_reg == '0 && out_port_reg == '0)
        else $error("miss result carries a route");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg &&
            $stable(found_reg) && $stable(route_index_reg) && $stable(out_port_reg))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/ipv4_longest_prefix_match.sv
// ipv4 longest prefix match routing table
//
// input channel (in_valid / in_stall): req_type 0 writes entry_prefix,
// entry_mask and entry_port at entry_index; writes at or beyond TABLE_DEPTH
// are dropped. req_type 1 looks up dest_ip over entries 0 .. entries_in_use-1
// (count saturated to TABLE_DEPTH); the longest mask wins, ties go to the
// later entry. writes give no result, every lookup gives one item on the
// output channel (out_valid / out_stall): found, route_index, out_port.
// config channel (cfg_valid / cfg_ready) sets entries_in_use; always ready,
// write it only while no lookup is in flight
//
// a lookup holds the table scanner through its scan, drain and finish states:
// one entry per cycle out of the table memory's registered read port, plus
// read and compare stages and the result load. a write is stored as the scanner
// takes it. a lookup passes input register, queue, scanner and result register.
// a two-entry queue between the input register and the scanner keeps taking
// items while a scan runs, and the output register holds a finished result
// under out_stall while the next lookup scans; that scan then waits at its end.
// reset clears the control state and entries_in_use; table contents are
// undefined until written, and no clearing pass is run
`default_nettype none

module ipv4_longest_prefix_match #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpm_pkg::COUNT_W-1:0]   cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [lpm_pkg::IDX_W-1:0]     entry_index,
    input  wire logic [lpm_pkg::ADDR_W-1:0]    entry_prefix,
    input  wire logic [lpm_pkg::ADDR_W-1:0]    entry_mask,
    input  wire logic [lpm_pkg::PORT_W-1:0]    entry_port,
    input  wire logic [lpm_pkg::ADDR_W-1:0]    dest_ip,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic [lpm_pkg::IDX_W-1:0]          route_index,
    output logic [lpm_pkg::PORT_W-1:0]         out_port
);
    import lpm_pkg::*;

    logic [COUNT_W-1:0] entries_in_use_reg;

    // front to queue
    logic               fq_valid;
    logic               fq_ready;
    lpm_cmd_t           fq_cmd;

    // queue to scanner
    logic               qb_valid;
    logic               qb_ready;
    lpm_cmd_t           qb_cmd;

    // configuration register, taken in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entries_in_use_reg <= cfg_data;
        end
    end

    // input register and request decode
    lpm_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .entry_prefix (entry_prefix),
        .entry_mask   (entry_mask),
        .entry_port   (entry_port),
        .dest_ip      (dest_ip),
        .push_valid   (fq_valid),
        .push_ready   (fq_ready),
        .push_cmd     (fq_cmd)
    );

    // decoupling queue
    lpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // table memory, scan sequencer and result register
    lpm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .entries_in_use (entries_in_use_reg),
        .cmd_valid      (qb_valid),
        .cmd_ready      (qb_ready),
        .cmd            (qb_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .route_index    (route_index),
        .out_port       (out_port)
    );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lpm_pkg::*;

    localparam int unsigned TABLE_DEPTH   = 256;
    localparam int unsigned ITEM_TARGET   = 1850;
    // idle cycles before a count change, so trailing writes leave the scanner
    localparam int unsigned SETTLE_CYCLES = 32;
    // longest scan plus pipeline, with margin, before the final verdict
    localparam int unsigned TAIL_CYCLES   = 300;
    // run time limit in ns, several times the slowest legal run
    localparam int unsigned RUN_LIMIT_NS  = 40_000_000;
    localparam int unsigned MAX_REPORTS   = 100;

    // receiver back-pressure styles, picked at random by the receiver
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPRINKLE,
        STALL_RUNS,
        STALL_HEAVY
    } stall_mode_t;

    // one item waiting to go into the block
    typedef struct {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   index;
        logic [ADDR_W-1:0]  prefix;
        logic [ADDR_W-1:0]  mask;
        logic [PORT_W-1:0]  port;
        logic [ADDR_W-1:0]  ip;
        bit                 after_drain;   // hold back until no lookup is outstanding
    } route_req_t;

    // what a lookup should answer
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [PORT_W-1:0]  port;
    } route_answer_t;

    // dut signals, all known from time zero
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic                req_type     = 1'b0;
    logic [IDX_W-1:0]    entry_index  = '0;
    logic [ADDR_W-1:0]   entry_prefix = '0;
    logic [ADDR_W-1:0]   entry_mask   = '0;
    logic [PORT_W-1:0]   entry_port   = '0;
    logic [ADDR_W-1:0]   dest_ip      = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                found;
    logic [IDX_W-1:0]    route_index;
    logic [PORT_W-1:0]   out_port;

    // stimulus side: items not yet driven and the table as the generator planned it
    route_req_t          request_queue [$];
    logic [ADDR_W-1:0]   planned_prefix  [TABLE_DEPTH];
    logic [ADDR_W-1:0]   planned_mask    [TABLE_DEPTH];
    bit                  planned_written [TABLE_DEPTH];
    int unsigned         items_queued = 0;

    // routing table mirror, updated on every accepted write
    logic [ADDR_W-1:0]   route_prefix [TABLE_DEPTH];
    logic [ADDR_W-1:0]   route_mask   [TABLE_DEPTH];
    logic [PORT_W-1:0]   route_port   [TABLE_DEPTH];
    logic [COUNT_W-1:0]  search_count;

    // answers owed by the block, oldest first
    route_answer_t       pending_answers [$];
    int unsigned         error_count = 0;

    // sender burst shaping
    route_req_t          next_req;
    int unsigned         burst_left;
    int unsigned         gap_left;

    // receiver stall pattern
    stall_mode_t         stall_mode;
    int unsigned         mode_left;
    int unsigned         run_left;
    logic                run_stall;

    route_answer_t       want;

    ipv4_longest_prefix_match #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .entry_prefix (entry_prefix),
        .entry_mask   (entry_mask),
        .entry_port   (entry_port),
        .dest_ip      (dest_ip),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .route_index  (route_index),
        .out_port     (out_port)
    );

    always #5 clk = ~clk;

    // longest prefix search over the mirrored table; the last entry with the
    // largest matching mask wins, count saturates at the table depth
    function automatic route_answer_t predict_route(input logic [ADDR_W-1:0] ip);
        route_answer_t     res;
        logic [ADDR_W-1:0] best_mask;
        int unsigned       span;
        res       = '0;
        best_mask = '0;
        span      = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : search_count;
        for (int unsigned i = 0; i < span; i++)
        begin
            if (((ip & route_mask[i]) == route_prefix[i]) && (route_mask[i] >= best_mask))
            begin
                best_mask = route_mask[i];
                res.found = 1'b1;
                res.index = IDX_W'(i);
                res.port  = route_port[i];
            end
        end
        return res;
    endfunction

    task automatic queue_write(input logic [IDX_W-1:0]  idx,
                               input logic [ADDR_W-1:0] prefix,
                               input logic [ADDR_W-1:0] mask,
                               input logic [PORT_W-1:0] port);
        route_req_t req;
        req.kind        = CMD_WRITE;
        req.index       = idx;
        req.prefix      = prefix;
        req.mask        = mask;
        req.port        = port;
        req.ip          = $urandom;   // unused by a write, kept busy anyway
        req.after_drain = 1'b0;
        request_queue.push_back(req);
        planned_prefix[idx]  = prefix;
        planned_mask[idx]    = mask;
        planned_written[idx] = 1'b1;
        items_queued++;
    endtask

    task automatic queue_lookup(input logic [ADDR_W-1:0] ip, input bit after_drain);
        route_req_t req;
        req.kind        = CMD_LOOKUP;
        req.index       = IDX_W'($urandom_range(0, 255));
        req.prefix      = $urandom;
        req.mask        = $urandom;
        req.port        = PORT_W'($urandom_range(0, 255));
        req.ip          = ip;
        req.after_drain = after_drain;
        request_queue.push_back(req);
        items_queued++;
    endtask

    // new entry: mostly contiguous masks, some copies of live entries to force
    // ties, some default routes, some odd masks and some that can never match
    task automatic queue_random_write(input int unsigned idx, input int unsigned span);
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        int unsigned       r;
        int unsigned       len;
        int unsigned       j;
        r = $urandom_range(0, 99);
        if (r >= 60 && r < 80 && span > 0)
        begin
            j      = $urandom_range(0, span - 1);
            prefix = planned_prefix[j];
            mask   = planned_mask[j];
        end
        else if (r >= 80 && r < 88)
        begin
            prefix = '0;
            mask   = '0;
        end
        else if (r >= 88 && r < 94)
        begin
            mask   = $urandom;
            prefix = $urandom & mask;
        end
        else if (r >= 94)
        begin
            mask   = $urandom;
            prefix = $urandom;
        end
        else
        begin
            len    = $urandom_range(1, ADDR_W);
            mask   = {ADDR_W{1'b1}} << (ADDR_W - len);
            prefix = $urandom & mask;
        end
        queue_write(IDX_W'(idx), prefix, mask, PORT_W'($urandom_range(0, 255)));
    endtask

    // mostly an address inside some searched entry's network, else anything
    function automatic logic [ADDR_W-1:0] aimed_address(input int unsigned span);
        int unsigned j;
        if (span > 0 && $urandom_range(0, 4) != 0)
        begin
            j = $urandom_range(0, span - 1);
            return (planned_prefix[j] & planned_mask[j]) | ($urandom & ~planned_mask[j]);
        end
        return $urandom;
    endfunction

    // idle means nothing queued, nothing on the wires and no answer owed;
    // sampled on the falling edge so all edge updates have landed
    task automatic wait_idle();
        do @(negedge clk);
        while (request_queue.size() != 0 || in_valid || pending_answers.size() != 0);
    endtask

    task automatic set_search_count(input logic [COUNT_W-1:0] count);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        end
    endtask

    // sender: takes items from the queue in bursts, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            search_count = '0;
            burst_left   = 0;
            gap_left     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                search_count = cfg_data;

            // accepted item: lookups owe an answer, writes update the mirror
            if (in_valid && !in_stall)
            begin
                if (req_type == CMD_LOOKUP)
                    pending_answers.push_back(predict_route(dest_ip));
                else if (entry_index < TABLE_DEPTH)
                begin
                    route_prefix[entry_index] = entry_prefix;
                    route_mask[entry_index]   = entry_mask;
                    route_port[entry_index]   = entry_port;
                end
            end

            // slot is free: either idle out a gap or present the next item
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() != 0 &&
                         !(request_queue[0].after_drain && pending_answers.size() != 0))
                begin
                    next_req     = request_queue.pop_front();
                    req_type     <= next_req.kind;
                    entry_index  <= next_req.index;
                    entry_prefix <= next_req.prefix;
                    entry_mask   <= next_req.mask;
                    entry_port   <= next_req.port;
                    dest_ip      <= next_req.ip;
                    in_valid     <= 1'b1;
                    // end of burst picks the next burst and the gap before it
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 47);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                                 : $urandom_range(0, 3);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall style changes now and then, including long clean stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode = STALL_NONE;
            mode_left  = 0;
            run_left   = 0;
            run_stall  = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(50, 400);
            end
            else
                mode_left--;

            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_SPRINKLE: out_stall <= ($urandom_range(0, 2) == 0);
                STALL_RUNS:
                begin
                    if (run_left == 0)
                    begin
                        run_stall = !run_stall;
                        run_left  = run_stall ? $urandom_range(1, 30) : $urandom_range(1, 10);
                    end
                    else
                        run_left--;
                    out_stall <= run_stall;
                end
                default:        out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checker: every accepted result against the oldest owed answer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $error("result with no lookup outstanding: %s %0b %0d %0d",
                           "found route_index out_port", found, route_index, out_port);
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("route_index", 32'(want.index), 32'(route_index));
                check_field("out_port", 32'(want.port), 32'(out_port));
            end
        end
    end

    initial
    begin
        int unsigned        phase;
        int unsigned        span;
        int unsigned        n;
        int unsigned        r;
        logic [COUNT_W-1:0] count;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // count is zero out of reset: no entry searched, nothing found
        queue_lookup(32'h0000_0000, 1'b0);
        queue_lookup(32'hFFFF_FFFF, 1'b0);

        // small hand-built table
        queue_write(8'd0, 32'h0000_0000, 32'h0000_0000, 8'hFF);   // default route
        queue_write(8'd1, 32'h0A00_0000, 32'hFF00_0000, 8'h01);
        queue_write(8'd2, 32'h0A01_0000, 32'hFFFF_0000, 8'h02);
        queue_write(8'd3, 32'h0A01_0000, 32'hFFFF_0000, 8'h03);   // same mask as 2, later wins
        queue_write(8'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h80);   // all-ones host route
        queue_write(8'd5, 32'h0000_FFFF, 32'hFFFF_0000, 8'h55);   // prefix outside mask, dead
        queue_write(8'd6, 32'h8000_0000, 32'h8000_0000, 8'hAA);
        queue_write(8'd7, 32'h0A01_0203, 32'hFFFF_FFFF, 8'h00);   // host route, port zero

        set_search_count(9'd8);
        queue_lookup(32'h0A01_01FF, 1'b0);   // tie between 2 and 3
        queue_lookup(32'h0A02_0304, 1'b0);
        queue_lookup(32'h0A01_0203, 1'b0);
        queue_lookup(32'h0B00_0000, 1'b0);   // only the default route
        queue_lookup(32'hFFFF_FFFF, 1'b0);
        queue_lookup(32'h8000_0001, 1'b1);   // sender waits for the block to empty
        queue_lookup(32'h0000_FFFF, 1'b0);

        // single entry searched, then it stops being a default route
        set_search_count(9'd1);
        queue_lookup(32'h1234_5678, 1'b0);
        queue_write(8'd0, 32'h0A00_0000, 32'hFF00_0000, 8'h11);
        queue_lookup(32'h0B00_0000, 1'b0);
        queue_lookup(32'h0A00_0001, 1'b0);

        // count written back to zero with a live table
        set_search_count(9'd0);
        queue_lookup(32'h0A00_0001, 1'b0);

        // random phases: count changes only with the block idle; every entry
        // under the count is written before the first lookup of the phase
        phase = 0;
        while (items_queued < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (phase == 1)
                count = 9'd511;   // far above depth, saturates
            else if (phase == 3)
                count = 9'd256;
            else if (r < 4)
                count = '0;
            else if (r < 8)
                count = ($urandom_range(0, 1) != 0) ? 9'd511
                                                   : COUNT_W'($urandom_range(257, 510));
            else if (r < 12)
                count = 9'd256;
            else if (r < 22)
                count = COUNT_W'($urandom_range(17, 64));
            else
                count = COUNT_W'($urandom_range(1, 16));
            span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;

            set_search_count(count);
            for (int unsigned i = 0; i < span; i++)
                if (!planned_written[i])
                    queue_random_write(i, i);

            // full-table scans are slow, so those phases stay short
            n = (span >= 128) ? $urandom_range(4, 10) : $urandom_range(10, 60);
            repeat (n)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    if (span > 0 && $urandom_range(0, 3) != 0)
                        queue_random_write($urandom_range(0, span - 1), span);
                    else
                        queue_random_write($urandom_range(0, TABLE_DEPTH - 1), span);
                end
                else
                    queue_lookup(aimed_address(span), $urandom_range(0, 49) == 0);
            end
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
